// ----- sv/grt3d_pkg.sv -----
`default_nettype none
package grt3d_pkg;

    localparam int COORD_WIDTH = 32;

    localparam int TW = 31;
    localparam logic [TW-1:0] T_MAX = {TW{1'b1}};

    localparam logic [2:0] REG_MIN_X   = 3'd0;
    localparam logic [2:0] REG_MIN_Y   = 3'd1;
    localparam logic [2:0] REG_MIN_Z   = 3'd2;
    localparam logic [2:0] REG_WIDTH_X = 3'd3;
    localparam logic [2:0] REG_WIDTH_Y = 3'd4;
    localparam logic [2:0] REG_WIDTH_Z = 3'd5;
    localparam logic [2:0] REG_SHIFT   = 3'd6;

    typedef struct packed {
        logic [COORD_WIDTH-1:0] origin_x;
        logic [COORD_WIDTH-1:0] origin_y;
        logic [COORD_WIDTH-1:0] origin_z;
        logic [COORD_WIDTH-1:0] dir_x;
        logic [COORD_WIDTH-1:0] dir_y;
        logic [COORD_WIDTH-1:0] dir_z;
        logic [30:0]            length_limit;
    } t_ray;

    typedef struct packed {
        logic [11:0] cell_index;
        logic [3:0]  cell_x;
        logic [3:0]  cell_y;
        logic [3:0]  cell_z;
        logic        last;
    } t_cell;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CELL_START,
        ST_CELL_DIV,
        ST_CELL_CHECK,
        ST_CROSS_START,
        ST_CROSS_DIV,
        ST_STEP_START,
        ST_STEP_DIV,
        ST_NEXT_AXIS,
        ST_EMIT,
        ST_WAIT
    } t_state;

endpackage
`default_nettype wire

// ----- sv/grid_ray_traversal_3ddda.sv -----
// 3d-dda grid walker: one ray item in, one item per visited cell out.
// input channel i_ray_*: origin and direction in q16.16, length limit in q15.16.
// output channel o_cell_*: cell index and coordinates, last set on the final
// cell of a ray. configuration writes go through i_cfg_we / i_cfg_index /
// i_cfg_data; the user must write them only while the block is idle, which
// the block itself does not enforce. setup runs per axis on one shared
// restoring divider that produces one quotient bit per cycle over 50 bits:
// a load state and a division each for the cell search, the crossing t and
// the step t, with a range check after the cell search and an axis advance
// after the step t. once all three axes are set up, each cell item is
// registered in the emit state, which picks the axis, and the wait state
// updates the cell and crossing t of that axis.
// the input is not ready during a walk; with a nonzero grid shift, a ray
// whose origin is outside the grid yields no items. a stalled receiver
// holds the current cell item in the output register and the walk pauses.
// reset (synchronous, active low) returns to idle and loads the register
// defaults.
`default_nettype none
module grid_ray_traversal_3ddda #(
    parameter int MAX_GRID_SHIFT = 4
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_ray_valid,
    output logic                     o_ray_ready,
    input  wire grt3d_pkg::t_ray     i_ray,
    output logic                     o_cell_valid,
    input  wire logic                i_cell_ready,
    output grt3d_pkg::t_cell         o_cell,
    input  wire logic                i_cfg_we,
    input  wire logic [2:0]          i_cfg_index,
    input  wire logic [grt3d_pkg::COORD_WIDTH-1:0] i_cfg_data
);
    import grt3d_pkg::*;

    localparam int CW = COORD_WIDTH;
    localparam int NW = CW + 2;          // numerator / difference width
    localparam int DW = NW + 16;         // dividend with fraction
    localparam int SW = 3;
    localparam int QB = $clog2(DW + 1);
    localparam logic [5:0] CNT_LAST = 6'(3 * ((1 << MAX_GRID_SHIFT) - 1));

    logic signed [CW-1:0] r_min [3];
    logic [30:0]          r_cw  [3];
    logic [2:0]           r_shift;

    t_state r_state, n_state;
    t_ray   r_ray;
    logic [1:0] r_ax;
    logic [3:0] r_cell [3];
    logic [TW-1:0] r_nct [3];
    logic [TW-1:0] r_cst [3];
    logic [2:0] r_neg;
    logic       r_ovalid;
    t_cell      r_out;
    logic [5:0] r_cnt;
    logic [1:0] r_sel;

    // divider
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_quo;
    logic [DW-1:0] r_num;
    logic [NW-1:0] r_den;
    logic [QB-1:0] r_bit;
    logic          r_negd;

    logic [SW-1:0] sh;
    assign sh = (r_shift > SW'(MAX_GRID_SHIFT)) ? SW'(MAX_GRID_SHIFT) : r_shift;

    // per-axis operand selection
    logic signed [CW-1:0] o_ax, d_ax, mn_ax;
    logic [NW-1:0] cw_ax;

    logic signed [CW-1:0] ox [3];
    logic signed [CW-1:0] dx [3];
    assign ox[0] = CW'(signed'(r_ray.origin_x));
    assign ox[1] = CW'(signed'(r_ray.origin_y));
    assign ox[2] = CW'(signed'(r_ray.origin_z));
    assign dx[0] = CW'(signed'(r_ray.dir_x));
    assign dx[1] = CW'(signed'(r_ray.dir_y));
    assign dx[2] = CW'(signed'(r_ray.dir_z));
    assign o_ax  = ox[r_ax];
    assign d_ax  = dx[r_ax];
    assign mn_ax = r_min[r_ax];
    assign cw_ax = (r_cw[r_ax] == '0) ? NW'(1) : NW'(r_cw[r_ax]);

    logic signed [NW-1:0] diff;
    assign diff = NW'(o_ax) - NW'(mn_ax);
    logic [NW-1:0] absd;
    assign absd = d_ax[CW-1] ? NW'(-NW'(d_ax)) : NW'(d_ax);
    logic pos;
    assign pos = !d_ax[CW-1] && (d_ax != '0);

    // divider step
    logic [DW:0] trial;
    assign trial = {r_rem[DW-1:0], r_num[DW-1]} - {1'b0, {(DW-NW){1'b0}}, r_den};

    logic [DW-1:0] q_full;
    assign q_full = {r_quo[DW-2:0], ~trial[DW]};

    logic [TW-1:0] tq;
    assign tq = (r_quo > DW'(T_MAX)) ? T_MAX : TW'(r_quo);

    // axis choice
    logic [1:0] pick;
    always_comb begin
        if (r_nct[0] < r_nct[1]) pick = (r_nct[0] < r_nct[2]) ? 2'd0 : 2'd2;
        else                     pick = (r_nct[1] < r_nct[2]) ? 2'd1 : 2'd2;
    end

    logic [3:0] size_m1;
    assign size_m1 = 4'((5'd1 << sh) - 5'd1);
    logic stop;
    always_comb begin
        if (r_ray.length_limit < r_nct[pick]) stop = 1'b1;
        else if (r_neg[pick]) stop = (r_cell[pick] == '0);
        else stop = (r_cell[pick] >= size_m1);
    end
    logic [11:0] idx;
    assign idx = 12'(r_cell[0]) + (12'(r_cell[1]) << sh) + (12'(r_cell[2]) << (2 * sh));

    assign o_ray_ready  = (r_state == ST_IDLE);
    assign o_cell_valid = r_ovalid;
    assign o_cell       = r_out;

    // cell = floor(diff / cw): divide |diff|, fix sign using remainder
    logic [NW-1:0] remv;
    assign remv = NW'(r_rem);

    // cell value after cell-division (quotient in r_quo, nonzero-remainder flag in r_rem)
    logic signed [NW+4:0] qcell;
    assign qcell = r_negd ? -(NW+5)'(r_quo) - ((remv != '0) ? 1 : 0) : (NW+5)'(r_quo);
    logic outside;
    assign outside = (sh != '0) && (qcell < 0 || qcell > (NW+5)'(size_m1));

    logic [3:0] cellv;
    assign cellv = (sh == '0) ? 4'd0 : 4'(qcell);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:        if (i_ray_valid) n_state = ST_CELL_START;
            ST_CELL_START:  n_state = ST_CELL_DIV;
            ST_CELL_DIV:    if (r_bit == '0) n_state = ST_CELL_CHECK;
            ST_CELL_CHECK:  n_state = outside ? ST_IDLE : ST_CROSS_START;
            ST_CROSS_START: n_state = ST_CROSS_DIV;
            ST_CROSS_DIV:   if (r_bit == '0) n_state = ST_STEP_START;
            ST_STEP_START:  n_state = ST_STEP_DIV;
            ST_STEP_DIV:    if (r_bit == '0) n_state = ST_NEXT_AXIS;
            ST_NEXT_AXIS:   n_state = (r_ax == 2'd2) ? ST_EMIT : ST_CELL_START;
            ST_EMIT: begin
                if (!r_ovalid || i_cell_ready)
                    n_state = (stop || r_cnt == CNT_LAST) ? ST_IDLE : ST_WAIT;
            end
            ST_WAIT:        n_state = ST_EMIT;
            default:        n_state = ST_IDLE;
        endcase
    end

    // boundary offset from origin: for pos, (cell+1)*cw - diff; else diff - cell*cw
    logic signed [NW+20:0] cb_off;
    logic signed [NW+20:0] diff_w;
    assign diff_w = (NW+21)'(diff);
    assign cb_off = pos ? ((NW+21)'(r_cell[r_ax]) + 1) * (NW+21)'(cw_ax) - diff_w
                        : diff_w - (NW+21)'(r_cell[r_ax]) * (NW+21)'(cw_ax);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
            r_shift  <= 3'd4;
            r_ax     <= 2'd0;
            r_cnt    <= '0;
            r_neg    <= '0;
            for (int k = 0; k < 3; k++) begin
                r_min[k]  <= '0;
                r_cw[k]   <= 31'd65536;
                r_cell[k] <= '0;
                r_nct[k]  <= '0;
                r_cst[k]  <= '0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_MIN_X:   r_min[0] <= i_cfg_data;
                    REG_MIN_Y:   r_min[1] <= i_cfg_data;
                    REG_MIN_Z:   r_min[2] <= i_cfg_data;
                    REG_WIDTH_X: r_cw[0]  <= 31'(i_cfg_data);
                    REG_WIDTH_Y: r_cw[1]  <= 31'(i_cfg_data);
                    REG_WIDTH_Z: r_cw[2]  <= 31'(i_cfg_data);
                    REG_SHIFT:   r_shift  <= 3'(i_cfg_data);
                    default: ;
                endcase
            end
            if (r_ovalid && i_cell_ready && r_state != ST_EMIT) r_ovalid <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    r_ray <= i_ray;
                    r_ax  <= 2'd0;
                    r_cnt <= '0;
                end
                ST_CELL_START: begin
                    r_negd <= diff[NW-1];
                    r_num  <= DW'(diff[NW-1] ? -diff : diff) << 16;
                    r_rem  <= '0;
                    r_quo  <= '0;
                    r_den  <= cw_ax;
                    r_bit  <= QB'(DW);
                end
                ST_CELL_DIV, ST_CROSS_DIV, ST_STEP_DIV: begin
                    if (r_bit != '0) begin
                        r_num <= r_num << 1;
                        r_quo <= q_full;
                        r_rem <= trial[DW] ? {r_rem[DW-2:0], r_num[DW-1]} : DW'(trial);
                        r_bit <= r_bit - 1'b1;
                    end else if (r_state == ST_CELL_DIV) begin
                        // undo the 16 fraction bits
                        r_rem <= DW'({r_quo[15:0] != '0 || r_rem != '0});
                        r_quo <= r_quo >> 16;
                    end else if (r_state == ST_CROSS_DIV) begin
                        r_nct[r_ax] <= (d_ax == '0) ? T_MAX : tq;
                    end else begin
                        r_cst[r_ax] <= (d_ax == '0) ? '0 : tq;
                    end
                end
                ST_CELL_CHECK: begin
                    r_cell[r_ax] <= cellv;
                    r_neg[r_ax]  <= !pos;
                end
                ST_CROSS_START: begin
                    r_num <= (cb_off <= 0) ? '0 : DW'(cb_off) << 16;
                    r_rem <= '0;
                    r_quo <= '0;
                    r_den <= absd;
                    r_bit <= QB'(DW);
                end
                ST_STEP_START: begin
                    r_num <= DW'(cw_ax) << 16;
                    r_rem <= '0;
                    r_quo <= '0;
                    r_den <= absd;
                    r_bit <= QB'(DW);
                end
                ST_NEXT_AXIS: r_ax <= (r_ax == 2'd2) ? 2'd0 : r_ax + 1'b1;
                ST_EMIT: begin
                    if (!r_ovalid || i_cell_ready) begin
                        r_ovalid         <= 1'b1;
                        r_out.cell_index <= idx;
                        r_out.cell_x     <= r_cell[0];
                        r_out.cell_y     <= r_cell[1];
                        r_out.cell_z     <= r_cell[2];
                        r_out.last       <= stop || (r_cnt == CNT_LAST);
                        r_cnt            <= r_cnt + 1'b1;
                        r_sel            <= pick;
                    end
                end
                ST_WAIT: begin
                    if (r_neg[r_sel]) r_cell[r_sel] <= r_cell[r_sel] - 1'b1;
                    else              r_cell[r_sel] <= r_cell[r_sel] + 1'b1;
                    r_nct[r_sel] <= (r_nct[r_sel] > T_MAX - r_cst[r_sel]) ? T_MAX
                                    : r_nct[r_sel] + r_cst[r_sel];
                end
                default: ;
            endcase
        end
    end

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ray_ready |-> (r_state == ST_IDLE)) else $error("ready outside idle");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cell_valid && !i_cell_ready) |=> $stable(o_cell)) else $error("out changed");
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cell_valid && !i_cell_ready) |=> o_cell_valid) else $error("valid dropped");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> !o_ray_ready) else $error("ready in walk");

endmodule
`default_nettype wire

// ----- sim/grt3d_walk_checker.sv -----
`timescale 1ns / 100ps
module grt3d_walk_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_ray_valid,
    input  logic                i_ray_ready,
    input  grt3d_pkg::t_ray     i_ray,
    input  logic                i_cell_valid,
    input  logic                i_cell_ready,
    input  grt3d_pkg::t_cell    i_cell,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_index,
    input  logic [31:0]         i_cfg_data,
    output int                  o_fail_count,
    output int                  o_cells_pending
);
    import grt3d_pkg::*;

    localparam longint T_SAT = 64'h7FFF_FFFF;
    localparam int MAX_CELLS = 46;

    longint          grid_min [3];
    longint          cell_w [3];
    logic [2:0]      shift_reg;
    t_cell           cells_due [$];

    function automatic longint t_quot(longint num, longint den);
        longint q;
        longint r;
        longint t;
        if (num >= (den << 15)) return T_SAT;
        q = num / den;
        r = num % den;
        t = (q << 16) + ((r << 16) / den);
        return (t > T_SAT) ? T_SAT : t;
    endfunction

    // walk one ray through the grid and queue every visited cell
    function automatic void walk_ray(t_ray r);
        int      sh;
        longint  size;
        longint  org [3];
        longint  dir [3];
        longint  cpos [3];
        longint  cross_t [3];
        longint  step_t [3];
        bit      neg [3];
        longint  diff;
        longint  cw;
        longint  cb;
        longint  num;
        longint  ad;
        longint  lim;
        int      ax;
        int      n;
        bit      stop;
        t_cell   c;
        sh = (shift_reg > 4) ? 4 : shift_reg;
        size = 64'd1 << sh;
        org[0] = $signed(r.origin_x);
        org[1] = $signed(r.origin_y);
        org[2] = $signed(r.origin_z);
        dir[0] = $signed(r.dir_x);
        dir[1] = $signed(r.dir_y);
        dir[2] = $signed(r.dir_z);
        lim = r.length_limit;
        for (int a = 0; a < 3; a++) begin
            cw = (cell_w[a] == 0) ? 1 : cell_w[a];
            diff = org[a] - grid_min[a];
            cpos[a] = (diff >= 0) ? diff / cw : -((-diff + cw - 1) / cw);
            if (size == 1) cpos[a] = 0;
            else if (cpos[a] < 0 || cpos[a] >= size) return;
        end
        for (int a = 0; a < 3; a++) begin
            cw = (cell_w[a] == 0) ? 1 : cell_w[a];
            neg[a] = !(dir[a] > 0);
            cb = grid_min[a] + (cpos[a] + (neg[a] ? 0 : 1)) * cw;
            if (dir[a] == 0) begin
                cross_t[a] = T_SAT;
                step_t[a] = 0;
            end else begin
                num = neg[a] ? org[a] - cb : cb - org[a];
                ad = neg[a] ? -dir[a] : dir[a];
                cross_t[a] = (num <= 0) ? 0 : t_quot(num, ad);
                step_t[a] = t_quot(cw, ad);
            end
        end
        n = 0;
        forever begin
            c.cell_x = cpos[0][3:0];
            c.cell_y = cpos[1][3:0];
            c.cell_z = cpos[2][3:0];
            c.cell_index = 12'(cpos[0] + (cpos[1] << sh) + (cpos[2] << (2 * sh)));
            n++;
            // smallest crossing moves, ties to z then y
            if (cross_t[0] < cross_t[1]) ax = (cross_t[0] < cross_t[2]) ? 0 : 2;
            else ax = (cross_t[1] < cross_t[2]) ? 1 : 2;
            if (lim < cross_t[ax]) begin
                stop = 1;
            end else if (neg[ax]) begin
                stop = (cpos[ax] == 0);
                if (!stop) cpos[ax]--;
            end else begin
                stop = (cpos[ax] >= size - 1);
                if (!stop) cpos[ax]++;
            end
            c.last = stop || (n == MAX_CELLS);
            cells_due.push_back(c);
            if (c.last) break;
            cross_t[ax] = (cross_t[ax] + step_t[ax] > T_SAT) ? T_SAT
                                                              : cross_t[ax] + step_t[ax];
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < 3; a++) begin
                grid_min[a] = 0;
                cell_w[a] = 64'h10000;
            end
            shift_reg = 3'd4;
            cells_due.delete();
            o_fail_count = 0;
            o_cells_pending = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_MIN_X:   grid_min[0] = $signed(i_cfg_data);
                    REG_MIN_Y:   grid_min[1] = $signed(i_cfg_data);
                    REG_MIN_Z:   grid_min[2] = $signed(i_cfg_data);
                    REG_WIDTH_X: cell_w[0] = i_cfg_data[30:0];
                    REG_WIDTH_Y: cell_w[1] = i_cfg_data[30:0];
                    REG_WIDTH_Z: cell_w[2] = i_cfg_data[30:0];
                    REG_SHIFT:   shift_reg = i_cfg_data[2:0];
                    default: ;
                endcase
            end
            if (i_cell_valid && i_cell_ready) begin
                if (cells_due.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("unexpected cell item %p", i_cell);
                end else begin
                    t_cell want;
                    want = cells_due.pop_front();
                    if (want !== i_cell) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display("cell mismatch: expected %p, got %p", want, i_cell);
                    end
                end
            end
            if (i_ray_valid && i_ray_ready) walk_ray(i_ray);
            o_cells_pending = cells_due.size();
        end
    end
endmodule

// ----- sim/grid_ray_traversal_3ddda_tb.sv -----
`timescale 1ns / 100ps
module grid_ray_traversal_3ddda_tb;
    import grt3d_pkg::*;

    localparam logic [2:0] REG_NONE = 3'd7;
    localparam logic [31:0] ONE = 32'h10000;
    localparam logic [30:0] LIM_MAX = 31'h7FFF_FFFF;
    localparam int SETTLE = 700;
    localparam int HOLD_CYCLES = 3000;
    localparam longint CYCLE_LIMIT = 3_000_000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_ray_valid;
    logic        o_ray_ready;
    t_ray        i_ray;
    logic        o_cell_valid;
    logic        i_cell_ready;
    t_cell       o_cell;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_index;
    logic [31:0] i_cfg_data;

    int          fail_count;
    int          cells_pending;
    int          idle_pct;
    int          stall_pct;
    bit          hold_req;
    longint      cycles;
    longint      top_min [3];
    longint      top_cw [3];
    int          top_shift;

    grid_ray_traversal_3ddda i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ray_valid  (i_ray_valid),
        .o_ray_ready  (o_ray_ready),
        .i_ray        (i_ray),
        .o_cell_valid (o_cell_valid),
        .i_cell_ready (i_cell_ready),
        .o_cell       (o_cell),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    grt3d_walk_checker i_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ray_valid     (i_ray_valid),
        .i_ray_ready     (o_ray_ready),
        .i_ray           (i_ray),
        .i_cell_valid    (o_cell_valid),
        .i_cell_ready    (i_cell_ready),
        .i_cell          (o_cell),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_fail_count    (fail_count),
        .o_cells_pending (cells_pending)
    );

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // receiver: random stalls, or one long hold-off on request
    always begin
        @(negedge i_clk);
        if (hold_req) begin
            i_cell_ready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge i_clk);
            hold_req = 1'b0;
        end
        i_cell_ready = ($urandom_range(99) >= stall_pct);
    end

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        i_cfg_we = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic set_grid(input logic [31:0] mx, my, mz, wx, wy, wz,
                            input logic [2:0] sh);
        write_reg(REG_MIN_X, mx);
        write_reg(REG_MIN_Y, my);
        write_reg(REG_MIN_Z, mz);
        write_reg(REG_WIDTH_X, wx);
        write_reg(REG_WIDTH_Y, wy);
        write_reg(REG_WIDTH_Z, wz);
        write_reg(REG_SHIFT, {29'd0, sh});
        top_min[0] = $signed(mx);
        top_min[1] = $signed(my);
        top_min[2] = $signed(mz);
        top_cw[0] = wx[30:0];
        top_cw[1] = wy[30:0];
        top_cw[2] = wz[30:0];
        top_shift = (sh > 4) ? 4 : sh;
    endtask

    task automatic send_ray(input t_ray r);
        bit rdy;
        while ($urandom_range(99) < idle_pct) begin
            i_ray_valid = 1'b0;
            @(negedge i_clk);
        end
        i_ray_valid = 1'b1;
        i_ray = r;
        forever begin
            #1;
            rdy = o_ray_ready;
            @(posedge i_clk);
            if (rdy) break;
            @(negedge i_clk);
        end
        @(negedge i_clk);
    endtask

    // idle the block: all cells back, then room for a ray that yields nothing
    task automatic drain;
        i_ray_valid = 1'b0;
        while (cells_pending != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    function automatic t_ray mk_ray(input logic [31:0] ox, oy, oz, dx, dy, dz,
                                    input logic [30:0] lim);
        t_ray r;
        r = '{ox, oy, oz, dx, dy, dz, lim};
        return r;
    endfunction

    function automatic logic [31:0] rand_dir;
        logic [31:0] mag;
        if ($urandom_range(99) < 15) return 32'd0;
        mag = $urandom >> $urandom_range(0, 24);
        return $urandom_range(1) ? -mag : mag;
    endfunction

    function automatic logic [30:0] rand_limit;
        case ($urandom_range(3))
            0: return LIM_MAX;
            1: return 31'($urandom);
            2: return 31'($urandom_range(0, 20 * ONE));
            default: return 31'($urandom >> $urandom_range(0, 30));
        endcase
    endfunction

    function automatic logic [31:0] inside_coord(input int a);
        longint cw;
        longint span;
        longint v;
        cw = (top_cw[a] == 0) ? 1 : top_cw[a];
        span = cw << top_shift;
        v = top_min[a] + (longint'({$urandom, $urandom} & 64'h7FFF_FFFF_FFFF) % span);
        if (v > 64'sh7FFF_FFFF || v < -64'sh8000_0000) v = top_min[a];
        return v[31:0];
    endfunction

    function automatic t_ray rand_ray;
        if ($urandom_range(99) < 15)
            return mk_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                          31'($urandom));
        return mk_ray(inside_coord(0), inside_coord(1), inside_coord(2),
                      rand_dir(), rand_dir(), rand_dir(), rand_limit());
    endfunction

    task automatic random_phase(input int count, input bit with_hold);
        for (int i = 0; i < count; i++) begin
            case ((i * 4) / count)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 58; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 58; end
                default: begin idle_pct = 33; stall_pct = 33; end
            endcase
            if (with_hold && i == 2) hold_req = 1'b1;
            // sender waits for every cell of the rays so far
            if (i == count / 2) drain();
            send_ray(rand_ray());
        end
        drain();
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_ray_valid = 1'b0;
        i_ray = '0;
        i_cell_ready = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = REG_MIN_X;
        i_cfg_data = '0;
        idle_pct = 0;
        stall_pct = 0;
        hold_req = 1'b0;
        cycles = 0;
        for (int a = 0; a < 3; a++) begin
            top_min[a] = 0;
            top_cw[a] = ONE;
        end
        top_shift = 4;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed rays on the reset grid: 16 cells of 1.0 from the origin
        send_ray(mk_ray(ONE / 2, ONE / 2, ONE / 2, ONE, 0, 0, LIM_MAX));
        send_ray(mk_ray(ONE / 2, ONE / 2, ONE / 2, 0, 0, 0, LIM_MAX));
        send_ray(mk_ray(ONE / 2, ONE * 3, ONE * 5, 0, 0, 0, 31'd0));
        send_ray(mk_ray(ONE * 15 + ONE / 2, ONE * 15 + ONE / 2, ONE * 15 + ONE / 2,
                        -ONE, -ONE, -ONE, LIM_MAX));
        send_ray(mk_ray(ONE / 2, ONE / 2, ONE / 2, ONE, ONE + ONE / 10,
                        ONE + ONE / 5, LIM_MAX));
        send_ray(mk_ray(ONE, ONE, ONE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                        LIM_MAX));
        send_ray(mk_ray(ONE * 8, ONE * 8, ONE * 8, 32'h8000_0000, 32'h8000_0000,
                        32'h8000_0000, LIM_MAX));
        send_ray(mk_ray(ONE * 8, ONE * 8, ONE * 8, 32'd1, 32'hFFFF_FFFF, 32'd1,
                        LIM_MAX));
        send_ray(mk_ray(ONE * 3, ONE * 4, ONE * 5, ONE, ONE, ONE, 31'(ONE * 2)));
        send_ray(mk_ray(-32'sd1, ONE, ONE, ONE, 0, 0, LIM_MAX));
        send_ray(mk_ray(ONE, ONE * 16, ONE, ONE, 0, 0, LIM_MAX));
        send_ray(mk_ray(32'h7FFF_FFFF, 32'h8000_0000, 0, ONE, ONE, ONE, LIM_MAX));
        send_ray(mk_ray(0, 0, 32'h000F_FFFF, 0, ONE, -ONE, LIM_MAX));
        drain();
        write_reg(REG_NONE, 32'hFFFF_FFFF);
        send_ray(mk_ray(ONE * 2, ONE * 2, ONE * 2, -ONE, ONE / 3, 0, LIM_MAX));
        drain();

        random_phase(40, 1'b0);
        set_grid(-32'sd196608, -32'sd98304, 32'd6553600, 32'h8000, 32'h30000, 32'd1,
                 3'd2);
        random_phase(52, 1'b1);
        set_grid(32'h8000_0000, 32'h7FFF_FFFF, 0, 32'h7FFF_FFFF, 32'd1, ONE, 3'd0);
        random_phase(44, 1'b0);
        set_grid(0, 32'h0001_2345, 32'h8000_0000, 32'h8000_0000, 32'h100,
                 32'hFFFF_FFFF, 3'd7);
        random_phase(48, 1'b0);
        set_grid(32'h0001_2345, -32'sd65536, 32'h0100_0000, 32'h18000, 32'h7000,
                 32'h20000, 3'd1);
        random_phase(40, 1'b0);
        set_grid(-32'sd262144, -32'sd262144, -32'sd262144, 32'h8000, 32'h8000, 32'h8000,
                 3'd4);
        random_phase(44, 1'b0);

        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule

// ----- grid_ray_traversal_3ddda.f -----
sv/grt3d_pkg.sv
sv/grid_ray_traversal_3ddda.sv
sim/grt3d_walk_checker.sv
sim/grid_ray_traversal_3ddda_tb.sv
